// ===== hdl/wsd_pkg.sv =====
// Shared types and constants of the window steady-state detector.
// No dependencies; used by every module of the block.
`default_nettype none

package wsd_pkg;

  // Default sizes handed to the top-level parameters
  localparam int WINDOW_MAX_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int FIELD_W    = 16;
  localparam int WL_W       = 6;
  localparam int AMP_W      = 8;
  localparam int STEP_W     = 16;
  localparam int THR_W      = AMP_W + STEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OSC_AMP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd2;

  // Register reset values
  localparam logic [WL_W-1:0]   WL_RESET   = 6'd8;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 8'd3;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;

  // Item codes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Per-cycle command shared by all cells of the row
  typedef struct packed {
    logic shift;   // take the neighbor below (insert a new sample)
    logic rot;     // take the neighbor above (scan rotation)
  } wsd_cell_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_PROD = 6'b000100,
    ST_THRL = 6'b001000,
    ST_FLAG = 6'b010000,
    ST_WAIT = 6'b100000
  } wsd_state_e;

endpackage

`default_nettype wire

// ===== hdl/wsd_cell.sv =====
// One sample cell of the window row: shifts up on insert, rotates down on scan.
// Depends on wsd_pkg for the cell command struct.
`default_nettype none

module wsd_cell
  import wsd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                   clk_i,
  input  wsd_cell_ctrl_t        ctrl_i,
  input  wire [SAMPLE_BITS-1:0] up_i,
  input  wire [SAMPLE_BITS-1:0] dn_i,
  output logic [SAMPLE_BITS-1:0] val_o
);

  logic [SAMPLE_BITS-1:0] val_q;

  always_ff @(posedge clk_i) begin
    priority if (ctrl_i.shift) begin
      val_q <= up_i;
    end else if (ctrl_i.rot) begin
      val_q <= dn_i;
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== hdl/wsd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wsd_pkg for the default operand width.
`default_nettype none

module wsd_div
  import wsd_pkg::*;
#(
  parameter int NUM_W = SAMPLE_BITS_DEF + 6,
  parameter int DEN_W = 6
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [NUM_W-1:0]  num_i,
  input  wire [DEN_W-1:0]  den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/window_steady_state_detector.sv =====
// Top level: sample cell row, scan accumulator, spread test and mean divider.
// Depends on wsd_pkg, wsd_cell and wsd_div.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------
//  in      | in_valid_i  | in_ready_o  | mode_i, sample_i
//  out     | out_valid_o | out_ready_i | steady_o, window_mean_o, window_full_o
//  cfg     | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// From one input beat to the next an item runs through these steps in order: one
// full rotation of the cell row feeds the accumulator, then the bit-serial divider
// forms the mean while the spread test runs beside it. The result shows in the
// same cycle as the block becomes ready to take the next beat.
// Reset empties the window and loads register defaults; the sample cells are not
// reset. A new beat is taken while a result still waits on the output register;
// the result of that beat then waits until the output register is free. Config
// beats are taken only while idle and win over an input beat in the same cycle.
`default_nettype none

module window_steady_state_detector
  import wsd_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   mode_i,
  input  wire [FIELD_W-1:0]     sample_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  steady_o,
  output logic [FIELD_W-1:0]    window_mean_o,
  output logic                  window_full_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int NW    = $clog2(WINDOW_MAX + 1);       // fill count / length
  localparam int KW    = $clog2(WINDOW_MAX);           // scan index
  localparam int LW    = (NW > WL_W) ? NW : WL_W;
  localparam int SUMW  = SAMPLE_BITS + NW;
  localparam int THRLW = THR_W + NW;
  localparam int CW    = (SUMW > THRLW) ? SUMW : THRLW;
  localparam int MW    = (SUMW > FIELD_W) ? SUMW : FIELD_W;

  // Registers
  logic [WL_W-1:0]   wl_q;
  logic [AMP_W-1:0]  amp_q;
  logic [STEP_W-1:0] step_q;
  logic [NW-1:0]     fill_q;
  wsd_state_e        state_q;
  logic [KW-1:0]     k_q;
  logic [SUMW-1:0]   sum_q;
  logic [SAMPLE_BITS-1:0] mx_q, mn_q;
  logic [THR_W-1:0]  thr_q;
  logic [SUMW-1:0]   mxn_q, mnn_q;
  logic [THRLW-1:0]  thrl_q;
  logic              full_q, flag_q;
  logic              out_valid_q, steady_q, full_out_q;
  logic [FIELD_W-1:0] mean_q;

  // Effective window length: zero reads as one, saturates at WINDOW_MAX
  logic [LW-1:0] wl_x, len_x;
  logic [NW-1:0] len;

  always_comb begin
    wl_x = LW'(wl_q);
    priority if (wl_q == '0) begin
      len_x = LW'(1);
    end else if (wl_x > LW'(WINDOW_MAX)) begin
      len_x = LW'(WINDOW_MAX);
    end else begin
      len_x = wl_x;
    end
    len = NW'(len_x);
  end

  logic in_fire, cfg_fire, out_free, out_load;
  assign in_ready_o  = (state_q == ST_IDLE) & ~cfg_valid_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;

  // Cell row: cell 0 holds the newest sample
  wsd_cell_ctrl_t         cell_ctrl;
  wire [SAMPLE_BITS-1:0]  cell_val [WINDOW_MAX];

  always_comb begin
    cell_ctrl.shift = in_fire & (mode_i == MODE_ADD);
    cell_ctrl.rot   = (state_q == ST_SCAN);
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] up, dn;
    if (i == 0) begin : g_head
      assign up = SAMPLE_BITS'(sample_i);
    end else begin : g_body
      assign up = cell_val[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign dn = cell_val[0];
    end else begin : g_mid
      assign dn = cell_val[i+1];
    end
    wsd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(cell_ctrl),
      .up_i  (up),
      .dn_i  (dn),
      .val_o (cell_val[i])
    );
  end

  // Mean divider
  logic            div_start, div_done;
  logic [SUMW-1:0] div_quo;
  assign div_start = (state_q == ST_PROD);

  wsd_div #(
    .NUM_W(SUMW),
    .DEN_W(NW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (sum_q),
    .den_i  (fill_q),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  assign out_load = (state_q == ST_WAIT) & div_done & out_free;

  // Spread test and mean clamp
  logic [CW-1:0]      upper, lower;
  logic [MW-1:0]      quo_x;
  logic [FIELD_W-1:0] mean_val;
  logic [SAMPLE_BITS-1:0] head;
  logic               head_valid;

  always_comb begin
    upper      = CW'(mxn_q) - CW'(sum_q);
    lower      = CW'(sum_q) - CW'(mnn_q);
    quo_x      = MW'(div_quo);
    mean_val   = (quo_x > MW'(16'hFFFF)) ? 16'hFFFF : quo_x[FIELD_W-1:0];
    head       = cell_val[0];
    head_valid = (NW'(k_q) < fill_q);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q        <= WL_RESET;
      amp_q       <= AMP_RESET;
      step_q      <= STEP_RESET;
      fill_q      <= '0;
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_WINDOW_LENGTH: begin
            wl_q   <= cfg_data_i[WL_W-1:0];
            fill_q <= '0;
          end
          CFG_OSC_AMP:   amp_q  <= cfg_data_i[AMP_W-1:0];
          CFG_STEP_SIZE: step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (mode_i == MODE_CLEAR) begin
              fill_q <= '0;
            end else if (fill_q < len) begin
              fill_q <= fill_q + 1'b1;
            end
            k_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          k_q <= k_q + 1'b1;
          if (k_q == KW'(WINDOW_MAX - 1)) begin
            state_q <= ST_PROD;
          end
        end
        ST_PROD: state_q <= ST_THRL;
        ST_THRL: state_q <= ST_FLAG;
        ST_FLAG: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_q <= '0;
      mx_q  <= '0;
      mn_q  <= '1;
    end else if ((state_q == ST_SCAN) && head_valid) begin
      sum_q <= sum_q + SUMW'(head);
      if (head > mx_q) begin
        mx_q <= head;
      end
      if (head < mn_q) begin
        mn_q <= head;
      end
    end
    if (state_q == ST_PROD) begin
      thr_q  <= THR_W'(amp_q) * THR_W'(step_q);
      mxn_q  <= SUMW'(mx_q) * SUMW'(fill_q);
      mnn_q  <= SUMW'(mn_q) * SUMW'(fill_q);
      full_q <= (fill_q != '0) && (fill_q >= len);
    end
    if (state_q == ST_THRL) begin
      thrl_q <= THRLW'(thr_q) * THRLW'(fill_q);
    end
    if (state_q == ST_FLAG) begin
      flag_q <= full_q && (upper < CW'(thrl_q)) && (lower < CW'(thrl_q));
    end
    if (out_load) begin
      steady_q   <= flag_q;
      full_out_q <= full_q;
      mean_q     <= (fill_q == '0) ? '0 : mean_val;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign steady_o      = steady_q;
  assign window_mean_o = mean_q;
  assign window_full_o = full_out_q;

endmodule

`default_nettype wire
